[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication at every rising clk edge outside reset.
`define STSK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define STSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/stsk_pkg.sv]
// ----------------------------------------------------------------------------
// stsk_pkg
// Shared types and constants of the Stirling number (second kind) unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stsk_pkg;

  localparam int unsigned MAX_ROW = 32;
  localparam int unsigned WORD_W  = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SIZE,
    ST_FILL,
    ST_RD,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_t;

  // request to the shared multiply-add unit
  typedef struct packed {
    logic  load;
    word_t mcand;
    word_t mplier;
    word_t addend;
  } mac_req_t;

  // result of the shared multiply-add unit
  typedef struct packed {
    word_t sum;
    logic  ovf;
  } mac_rsp_t;

endpackage

`default_nettype wire

[src/stsk_if.sv]
// ----------------------------------------------------------------------------
// stsk_if
// Valid/ready channels of the Stirling unit: operand input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface stsk_in_if;
  logic                valid;
  logic                ready;
  stsk_pkg::word_t     set_size;
  stsk_pkg::word_t     part_count;

  modport source (output valid, output set_size, output part_count, input ready);
  modport sink   (input valid, input set_size, input part_count, output ready);
endinterface

interface stsk_out_if;
  logic                valid;
  logic                ready;
  stsk_pkg::word_t     value;
  logic                overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

`default_nettype wire

[src/stsk_ram.sv]
// ----------------------------------------------------------------------------
// stsk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stsk_ram #(
  parameter int unsigned Width = stsk_pkg::WORD_W,
  parameter int unsigned Depth = stsk_pkg::MAX_ROW
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/stsk_mac.sv]
// ----------------------------------------------------------------------------
// stsk_mac
// Shared multiply-add unit: registered 32x32 product and addend, then
// a 33-bit add with overflow detect on both product and sum.
// ----------------------------------------------------------------------------
`default_nettype none

module stsk_mac (
  input  wire logic               clk,
  input  wire stsk_pkg::mac_req_t req,
  output stsk_pkg::mac_rsp_t      rsp
);

  localparam int unsigned W = stsk_pkg::WORD_W;

  logic [2*W-1:0]  prod_r;
  stsk_pkg::word_t add_r;
  logic [W:0]      sum_w;

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod_r <= (2*W)'(req.mcand) * (2*W)'(req.mplier);
      add_r  <= req.addend;
    end
  end

  assign sum_w   = (W+1)'(add_r) + (W+1)'(prod_r[W-1:0]);
  assign rsp.sum = sum_w[W-1:0];
  assign rsp.ovf = (prod_r[2*W-1:W] != '0) || sum_w[W];

endmodule

`default_nettype wire

[src/stirling_second_kind_unit_core.sv]
// ----------------------------------------------------------------------------
// stirling_second_kind_unit_core
// S(m,n) of the second kind as a 32-bit value with overflow flag, computed
// by a sequencer driving one shared multiply-add unit over a row RAM.
//
//   channel  dir  payload                         transfer
//   in_ch    in   set_size[31:0], part_count[31:0] valid & ready
//   out_ch   out  value[31:0], overflow            valid & ready
//
// Trivial operands go straight to the result; rows longer than MaxRow give
// an overflow result. Otherwise a row of d = min(n, m-n+1) entries is updated
// in passes i = 2..s, s = max(n, m-n+1); an overflow ends the work early.
// Each row entry update: RAM read, multiply, add and write back. in_ch.ready
// is high only while idle; a finished result holds until the output register
// is free. Reset is synchronous; every row entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stirling_second_kind_unit_core #(
  parameter int unsigned MaxRow = stsk_pkg::MAX_ROW
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  stsk_in_if.sink       in_ch,
  stsk_out_if.source    out_ch
);

  localparam int unsigned W    = stsk_pkg::WORD_W;
  localparam int unsigned IdxW = $clog2(MaxRow);
  localparam int unsigned CntW = $clog2(MaxRow + 1);

  stsk_pkg::state_t   st_r, st_nxt;
  stsk_pkg::word_t    m_r, m_nxt;
  stsk_pkg::word_t    n_r, n_nxt;
  stsk_pkg::word_t    other_r, other_nxt;
  stsk_pkg::word_t    s_r, s_nxt;
  stsk_pkg::word_t    i_r, i_nxt;
  stsk_pkg::word_t    prev_r, prev_nxt;
  stsk_pkg::word_t    res_value_r, res_value_nxt;
  stsk_pkg::word_t    out_value_r, out_value_nxt;
  logic [CntW-1:0]    d_r, d_nxt;
  logic [IdxW-1:0]    j_r, j_nxt;
  logic               by_part_r, by_part_nxt;
  logic               res_ovf_r, res_ovf_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_valid_r, out_valid_nxt;

  stsk_pkg::mac_req_t mac_req;
  stsk_pkg::mac_rsp_t mac_rsp;
  stsk_pkg::word_t    rdata;
  stsk_pkg::word_t    ram_wdata;
  logic               ram_we;

  logic               trivial_one;
  logic               trivial_zero;
  logic               by_part_w;
  stsk_pkg::word_t    d_w;
  stsk_pkg::word_t    s_w;
  logic               too_long;
  logic               last_j;
  logic               last_i;
  logic               out_free;

  stsk_ram #(
    .Width(W),
    .Depth(MaxRow)
  ) u_row (
    .clk  (clk),
    .we   (ram_we),
    .waddr(j_r),
    .wdata(ram_wdata),
    .raddr(j_r),
    .rdata(rdata)
  );

  stsk_mac u_mac (
    .clk(clk),
    .req(mac_req),
    .rsp(mac_rsp)
  );

  assign trivial_one  = (n_r == m_r) || (n_r == W'(1));
  assign trivial_zero = (n_r == '0) || (n_r > m_r);
  assign by_part_w    = (n_r <= other_r);
  assign d_w          = by_part_w ? n_r : other_r;
  assign s_w          = by_part_w ? other_r : n_r;
  assign too_long     = (d_w > W'(MaxRow));
  assign last_j       = (CntW'(j_r) == d_r - CntW'(1));
  assign last_i       = (i_r == s_r);
  assign out_free     = !out_valid_r || out_ch.ready;

  assign in_ch.ready     = (st_r == stsk_pkg::ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.overflow = out_ovf_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      stsk_pkg::ST_IDLE: begin
        if (in_ch.valid) st_nxt = stsk_pkg::ST_CLASS;
      end
      stsk_pkg::ST_CLASS: begin
        st_nxt = (trivial_one || trivial_zero) ? stsk_pkg::ST_EMIT : stsk_pkg::ST_SIZE;
      end
      stsk_pkg::ST_SIZE: begin
        st_nxt = too_long ? stsk_pkg::ST_EMIT : stsk_pkg::ST_FILL;
      end
      stsk_pkg::ST_FILL: begin
        if (last_j) st_nxt = stsk_pkg::ST_RD;
      end
      stsk_pkg::ST_RD:  st_nxt = stsk_pkg::ST_MUL;
      stsk_pkg::ST_MUL: st_nxt = stsk_pkg::ST_ADD;
      stsk_pkg::ST_ADD: begin
        priority if (mac_rsp.ovf)        st_nxt = stsk_pkg::ST_EMIT;
        else if (last_j && last_i)       st_nxt = stsk_pkg::ST_EMIT;
        else                             st_nxt = stsk_pkg::ST_RD;
      end
      stsk_pkg::ST_EMIT: begin
        if (out_free) st_nxt = stsk_pkg::ST_IDLE;
      end
      default: st_nxt = stsk_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    m_nxt         = m_r;
    n_nxt         = n_r;
    other_nxt     = other_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    by_part_nxt   = by_part_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    prev_nxt      = prev_r;
    res_value_nxt = res_value_r;
    res_ovf_nxt   = res_ovf_r;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_we        = 1'b0;
    ram_wdata     = mac_rsp.sum;

    mac_req.load   = 1'b0;
    mac_req.mcand  = by_part_r ? rdata : prev_r;
    mac_req.mplier = by_part_r ? W'(CntW'(j_r) + CntW'(1)) : i_r;
    mac_req.addend = by_part_r ? prev_r : rdata;

    unique case (st_r)
      stsk_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          m_nxt = in_ch.set_size;
          n_nxt = in_ch.part_count;
        end
      end
      stsk_pkg::ST_CLASS: begin
        other_nxt     = m_r - n_r + W'(1);
        res_value_nxt = trivial_one ? W'(1) : '0;
        res_ovf_nxt   = 1'b0;
      end
      stsk_pkg::ST_SIZE: begin
        by_part_nxt   = by_part_w;
        d_nxt         = CntW'(d_w);
        s_nxt         = s_w;
        i_nxt         = W'(2);
        j_nxt         = IdxW'(1);
        prev_nxt      = W'(1);
        res_value_nxt = '0;
        res_ovf_nxt   = 1'b1;
      end
      stsk_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = W'(1);
        j_nxt     = last_j ? IdxW'(1) : j_r + IdxW'(1);
      end
      stsk_pkg::ST_RD: begin
        // wait for the registered RAM read
      end
      stsk_pkg::ST_MUL: begin
        mac_req.load = 1'b1;
      end
      stsk_pkg::ST_ADD: begin
        priority if (mac_rsp.ovf) begin
          res_value_nxt = '0;
          res_ovf_nxt   = 1'b1;
        end else if (last_j && last_i) begin
          ram_we        = 1'b1;
          res_value_nxt = mac_rsp.sum;
          res_ovf_nxt   = 1'b0;
        end else if (last_j) begin
          // advance to next pass, row[0] stays 1
          ram_we   = 1'b1;
          i_nxt    = i_r + W'(1);
          j_nxt    = IdxW'(1);
          prev_nxt = W'(1);
        end else begin
          ram_we   = 1'b1;
          j_nxt    = j_r + IdxW'(1);
          prev_nxt = mac_rsp.sum;
        end
      end
      stsk_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_ovf_nxt   = res_ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= stsk_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r         <= m_nxt;
    n_r         <= n_nxt;
    other_r     <= other_nxt;
    d_r         <= d_nxt;
    s_r         <= s_nxt;
    by_part_r   <= by_part_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    prev_r      <= prev_nxt;
    res_value_r <= res_value_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  `STSK_ASSERT(a_ovf_zero, (out_valid_r && out_ovf_r) |-> (out_value_r == '0), "overflow result with nonzero value")
  `STSK_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> ($past(st_r) == stsk_pkg::ST_EMIT), "result raised outside emit")
  `STSK_ASSERT(a_j_in_row, (st_r == stsk_pkg::ST_RD) |-> ((j_r != '0) && (CntW'(j_r) < d_r)), "row index out of range")
  `STSK_ASSERT_NEXT(a_rd_to_mul, (st_r == stsk_pkg::ST_RD), (st_r == stsk_pkg::ST_MUL), "read not followed by multiply")

endmodule

`default_nettype wire
